// File: hdl/xtc_pkg.sv
// Shared types, constants and helpers for the XOR-to-CNF clause encoder.
// No dependencies.
package xtc_pkg;

  localparam int LIT_W            = 24;
  localparam int FIRST_VAR_W      = 23;
  localparam int MAX_LITERALS_DEF = 16;
  localparam int VAR_BITS_DEF     = 23;
  localparam int QUEUE_DEPTH_DEF  = 4;

  typedef logic signed [LIT_W-1:0] lit_t;

  typedef enum logic [0:0] {
    CFG_POOL_MODE       = 1'b0,
    CFG_FIRST_FRESH_VAR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                   valid;
    cfg_reg_t               index;
    logic [FIRST_VAR_W-1:0] data;
  } cfg_wr_t;

  // one classified input beat
  typedef struct packed {
    lit_t lit;
    logic store;
    logic drop;
    logic last;
  } cmd_t;

  function automatic lit_t neg_lit(lit_t x);
    return lit_t'(LIT_W'(0) - x);
  endfunction

endpackage

// File: hdl/xtc_queue.sv
// Small command FIFO between front and back of the clause encoder.
// Depends on xtc_pkg (cmd_t).
module xtc_queue import xtc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/xtc_front.sv
// Input side: accepts literal beats, tracks buffer fill, classifies each beat.
// Depends on xtc_pkg; feeds xtc_queue.
module xtc_front import xtc_pkg::*; #(
  parameter int MAX_LITERALS = MAX_LITERALS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  lit_t literal,
  input  logic last_literal,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);

  localparam int CNT_W = $clog2(MAX_LITERALS + 1);

  logic [CNT_W-1:0] count;
  logic             accept;
  logic             is_zero;
  logic             is_full;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_zero  = (literal == '0);
  assign is_full  = (count == CNT_W'(MAX_LITERALS));

  always_comb begin
    q_cmd.lit   = literal;
    q_cmd.store = !is_zero && !is_full;
    q_cmd.drop  = !is_zero && is_full;
    q_cmd.last  = last_literal;
    q_push      = accept && (q_cmd.store || q_cmd.drop || q_cmd.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (last_literal) begin
        count <= '0;
      end else if (q_cmd.store) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_LITERALS))
    else $error("literal count beyond buffer depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last_literal) |=> (count == '0))
    else $error("count not cleared after final literal");

endmodule

// File: hdl/xtc_back.sv
// Encoder side: loads queued literals into the working list and emits
// Tseitin XOR clauses one per cycle, unless out_ready stalls, through an
// output register. Depends on xtc_pkg; fed by xtc_queue.
module xtc_back import xtc_pkg::*; #(
  parameter int MAX_LITERALS = MAX_LITERALS_DEF,
  parameter int VAR_BITS     = VAR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output lit_t       lit_a,
  output lit_t       lit_b,
  output lit_t       lit_c,
  output logic [1:0] lit_count,
  output logic       error,
  output logic       last_clause
);

  localparam int IDX_W = $clog2(MAX_LITERALS);
  localparam int CNT_W = $clog2(MAX_LITERALS + 1);
  localparam int FV_W  = ((VAR_BITS > FIRST_VAR_W) ? VAR_BITS : FIRST_VAR_W) + 1;
  localparam int FVX_W = FV_W + 1;
  localparam logic [FV_W-1:0]  FV_TOP    = FV_W'(64'd1 << VAR_BITS);
  localparam logic [FVX_W-1:0] ERR_LIMIT = FVX_W'((64'd1 << VAR_BITS) + 64'd3);

  typedef enum logic [0:0] {ST_LOAD, ST_EMIT} state_t;

  state_t            st;
  lit_t              w       [MAX_LITERALS];
  lit_t              w_shift [MAX_LITERALS];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_load;
  logic [1:0]        phase;
  logic [FV_W-1:0]   fv;
  logic              pool_mode;
  logic              overflowed;
  logic              err_hold;
  logic              err_start;
  logic              adv;
  logic              reduce;
  logic              step_done;
  lit_t              fresh;
  lit_t              va, vb, vc;
  lit_t              c_a, c_b, c_c;
  logic [1:0]        c_cnt;
  logic              c_last;

  assign adv       = !out_valid || out_ready;
  assign reduce    = (n > CNT_W'(3));
  assign fresh     = lit_t'(fv[LIT_W-1:0]);
  assign va        = w[0];
  assign vb        = w[1];
  assign vc        = reduce ? fresh : w[2];
  assign step_done = (st == ST_EMIT) && adv && reduce && (phase == 2'd3);
  assign q_pop     = (st == ST_LOAD) && q_valid;
  assign n_load    = cnt + CNT_W'(q_cmd.store);

  // error flag covers every fresh variable this constraint will use
  always_comb begin
    err_start = overflowed || q_cmd.drop;
    if (n_load > CNT_W'(3)) begin
      if ((fv == '0) || (({1'b0, fv} + FVX_W'(n_load)) > ERR_LIMIT)) begin
        err_start = 1'b1;
      end
    end
  end

  always_comb begin
    c_a    = '0;
    c_b    = '0;
    c_c    = '0;
    c_cnt  = 2'd3;
    c_last = 1'b0;
    if (n == CNT_W'(0)) begin
      c_cnt  = 2'd0;
      c_last = 1'b1;
    end else if (n == CNT_W'(1)) begin
      c_a    = neg_lit(va);
      c_cnt  = 2'd1;
      c_last = 1'b1;
    end else if (n == CNT_W'(2)) begin
      c_cnt  = 2'd2;
      c_last = (phase == 2'd1);
      if (phase == 2'd0) begin
        c_a = va;
        c_b = neg_lit(vb);
      end else begin
        c_a = neg_lit(va);
        c_b = vb;
      end
    end else begin
      c_last = !reduce && (phase == 2'd3);
      case (phase)
        2'd0: begin
          c_a = va;          c_b = vb;          c_c = neg_lit(vc);
        end
        2'd1: begin
          c_a = va;          c_b = neg_lit(vb); c_c = vc;
        end
        2'd2: begin
          c_a = neg_lit(va); c_b = vb;          c_c = vc;
        end
        default: begin
          c_a = neg_lit(va); c_b = neg_lit(vb); c_c = neg_lit(vc);
        end
      endcase
    end
  end

  // list after one reduction: fresh var at front (chain) or back (pool)
  always_comb begin
    for (int i = 0; i < MAX_LITERALS; i++) begin
      w_shift[i] = w[i];
    end
    if (pool_mode) begin
      for (int i = 0; i < MAX_LITERALS - 2; i++) begin
        w_shift[i] = w[i + 2];
      end
      w_shift[IDX_W'(n - CNT_W'(2))] = fresh;
    end else begin
      w_shift[0] = fresh;
      for (int i = 0; i < MAX_LITERALS - 2; i++) begin
        w_shift[i + 1] = w[i + 2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.store) begin
      w[cnt[IDX_W-1:0]] <= q_cmd.lit;
    end else if (step_done) begin
      w <= w_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_LOAD;
      cnt        <= '0;
      n          <= '0;
      phase      <= '0;
      fv         <= FV_W'(1);
      pool_mode  <= 1'b0;
      overflowed <= 1'b0;
      err_hold   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_POOL_MODE:       pool_mode <= cfg.data[0];
          CFG_FIRST_FRESH_VAR: fv        <= FV_W'(cfg.data);
          default:             pool_mode <= pool_mode;
        endcase
      end
      if (out_valid && out_ready && (st != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_LOAD: begin
          if (q_valid) begin
            if (q_cmd.drop && !q_cmd.last) begin
              overflowed <= 1'b1;
            end
            if (q_cmd.last) begin
              n          <= n_load;
              cnt        <= '0;
              phase      <= '0;
              err_hold   <= err_start;
              overflowed <= err_start;
              st         <= ST_EMIT;
            end else begin
              cnt <= n_load;
            end
          end
        end
        ST_EMIT: begin
          if (adv) begin
            out_valid   <= 1'b1;
            lit_a       <= c_a;
            lit_b       <= c_b;
            lit_c       <= c_c;
            lit_count   <= c_cnt;
            error       <= err_hold;
            last_clause <= c_last;
            if (reduce) begin
              phase <= phase + 2'd1;
              if (phase == 2'd3) begin
                n <= n - CNT_W'(1);
                if (fv < FV_TOP) begin
                  fv <= fv + FV_W'(1);
                end
              end
            end else if (c_last) begin
              phase <= '0;
              st    <= ST_LOAD;
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        default: st <= ST_LOAD;
      endcase
    end
  end

  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT && adv && c_last) |=> (st == ST_LOAD))
    else $error("encoder did not return to load after final clause");

  a_fv_monotonic: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT && $past(st) == ST_EMIT) |-> (fv >= $past(fv)))
    else $error("fresh variable counter moved backward");

  a_no_pop_in_emit: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT) |-> !q_pop)
    else $error("queue popped while emitting");

endmodule

// File: hdl/xor_constraint_to_cnf.sv
// Top level of the XOR constraint to CNF clause encoder.
// Depends on xtc_pkg, xtc_front, xtc_queue, xtc_back.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid in_ready literal last_literal    | in
//  out     | out_valid out_ready lit_a lit_b lit_c     | out
//          | lit_count error last_clause               |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//
// A nonzero or final literal beat is queued when accepted; while loading,
// the back end moves one queued beat into the working list per cycle. On
// the final beat it emits 4*(n-3) reduction clauses plus 1, 2 or 4 closing
// clauses, one per cycle unless out_ready stalls, through the single clause
// output register. Reset: chain mode, fresh variable 1, empty buffer, error
// state clear. Output stalls back up through the queue to in_ready.
module xor_constraint_to_cnf import xtc_pkg::*; #(
  parameter int MAX_LITERALS = MAX_LITERALS_DEF,
  parameter int VAR_BITS     = VAR_BITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lit_t                   literal,
  input  logic                   last_literal,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lit_t                   lit_a,
  output lit_t                   lit_b,
  output lit_t                   lit_c,
  output logic [1:0]             lit_count,
  output logic                   error,
  output logic                   last_clause,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [FIRST_VAR_W-1:0] cfg_data
);

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    head_valid;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid;
    cfg.index = cfg_reg_t'(cfg_index);
    cfg.data  = cfg_data;
  end

  xtc_front #(
    .MAX_LITERALS (MAX_LITERALS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .literal      (literal),
    .last_literal (last_literal),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  xtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  xtc_back #(
    .MAX_LITERALS (MAX_LITERALS),
    .VAR_BITS     (VAR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (head_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lit_a       (lit_a),
    .lit_b       (lit_b),
    .lit_c       (lit_c),
    .lit_count   (lit_count),
    .error       (error),
    .last_clause (last_clause)
  );

endmodule
